@@ rtl/core/mod7_header_frame_deframer_assert.svh @@
// Assertion macros shared by the deframer modules.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef MOD7_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define MOD7_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define MHFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mhfd assertion failed");
`define MHFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mhfd assertion failed");
`else
`define MHFD_ASSERT(label, prop)
`define MHFD_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ rtl/core/mhfd_pkg.sv @@
// Package for the mod-7 header frame deframer: result codes, queue sizing,
// the queued result item, the configuration bundle and the header check helper.
package mhfd_pkg;

  localparam int TERM_W = 40;
  localparam int MAXP_W = 16;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 16'd512;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_ACCEPT   = 3'd1;
  localparam logic [2:0] KIND_BAD_HDR  = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_OVERSIZE = 3'd4;
  localparam logic [2:0] KIND_RESYNC   = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [7:0]  ftype;
    logic [7:0]  fprio;
    logic [15:0] flen;
    logic [15:0] idx;
  } res_item_t;

  typedef struct packed {
    logic [TERM_W-1:0] terminator_word;
    logic [MAXP_W-1:0] max_payload;
  } cfg_t;

  // Adds a byte into a running mod-7 residue; 8 and 64 are both 1 mod 7.
  function automatic logic [2:0] mod7_add(input logic [2:0] acc, input logic [7:0] b);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(b[7:6]) + 5'(b[5:3]) + 5'(b[2:0]) + 5'(acc);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

@@ rtl/core/mhfd_cfg.sv @@
// Configuration register file with its APB-style access port.
// Depends on mhfd_pkg for the configuration bundle and reset values.
module mhfd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               reg_sel,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output mhfd_pkg::cfg_t     cfg
);
  import mhfd_pkg::*;

  logic [TERM_W-1:0] terminator_word;
  logic [MAXP_W-1:0] max_payload;
  logic              wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator_word <= '0;
      max_payload     <= MAXP_RESET;
    end else if (wr_en) begin
      if (reg_sel) begin
        max_payload <= pwdata[MAXP_W-1:0];
      end else begin
        terminator_word <= pwdata[TERM_W-1:0];
      end
    end
  end

  assign prdata = reg_sel ? {{(64-MAXP_W){1'b0}}, max_payload}
                          : {{(64-TERM_W){1'b0}}, terminator_word};
  assign cfg.terminator_word = terminator_word;
  assign cfg.max_payload     = max_payload;

endmodule

@@ rtl/core/mhfd_front.sv @@
// Front end: accepts received bytes, tracks header, payload, trailer and hunt,
// and pushes one classified result into the queue. Depends on mhfd_pkg.
module mhfd_front #(
  parameter int TRAILER_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  mhfd_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [7:0]          rx_byte,
  output logic                in_ready,
  input  logic                q_full,
  output logic                q_push,
  output mhfd_pkg::res_item_t q_item
);
  import mhfd_pkg::*;

  localparam int W = 8 * TRAILER_BYTES;
  localparam int CNT_W = $clog2(TRAILER_BYTES + 1);
  localparam logic [CNT_W-1:0] TB_CNT = CNT_W'(TRAILER_BYTES);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;
  localparam logic [1:0] PH_HUNT    = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [2:0]       header_count, header_count_next;
  logic [2:0]       check_residue, check_residue_next;
  logic [7:0]       type_reg, type_reg_next;
  logic [7:0]       priority_reg, priority_reg_next;
  logic [15:0]      length_reg, length_reg_next;
  logic [15:0]      payload_count, payload_count_next;
  logic [W-1:0]     trailer_window, trailer_window_next;
  logic [CNT_W-1:0] trailer_count, trailer_count_next;

  logic [TERM_W+W-1:0] term_ext;
  logic [W-1:0]        term_cmp;
  logic [W-1:0]        window_shift;
  logic [CNT_W-1:0]    count_sat;
  logic [2:0]          residue_sum;
  logic                accept;
  logic                res_valid;
  res_item_t           res;

  assign term_ext     = {{W{1'b0}}, cfg.terminator_word};
  assign term_cmp     = term_ext[W-1:0];
  assign window_shift = W'({trailer_window, rx_byte});
  assign count_sat    = (trailer_count < TB_CNT) ? trailer_count + CNT_W'(1) : trailer_count;
  assign residue_sum  = mod7_add(check_residue, rx_byte);
  assign in_ready     = !q_full;
  assign accept       = in_valid && in_ready;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    check_residue_next  = check_residue;
    type_reg_next       = type_reg;
    priority_reg_next   = priority_reg;
    length_reg_next     = length_reg;
    payload_count_next  = payload_count;
    trailer_window_next = trailer_window;
    trailer_count_next  = trailer_count;
    res_valid           = 1'b0;
    res                 = '0;
    res.ftype           = type_reg;
    res.fprio           = priority_reg;
    res.flen            = length_reg;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          check_residue_next = residue_sum;
          unique case (header_count)
            3'd0:    type_reg_next = rx_byte;
            3'd1:    priority_reg_next = rx_byte;
            3'd2:    length_reg_next = {rx_byte, 8'd0};
            3'd3:    length_reg_next = {length_reg[15:8], rx_byte};
            default: ;
          endcase
          if (header_count < 3'd4) begin
            header_count_next = header_count + 3'd1;
          end else begin
            header_count_next   = '0;
            payload_count_next  = '0;
            trailer_window_next = '0;
            trailer_count_next  = '0;
            if (residue_sum != 3'd0) begin
              check_residue_next = '0;
              res_valid          = 1'b1;
              res.kind           = KIND_BAD_HDR;
              phase_next         = PH_HUNT;
            end else if (length_reg > cfg.max_payload) begin
              res_valid  = 1'b1;
              res.kind   = KIND_OVERSIZE;
              phase_next = PH_HUNT;
            end else begin
              phase_next = (length_reg == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid          = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.data           = rx_byte;
          res.idx            = payload_count;
          payload_count_next = payload_count + 16'd1;
          if (payload_count_next >= length_reg) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          trailer_window_next = window_shift;
          trailer_count_next  = count_sat;
          if (count_sat == TB_CNT) begin
            res_valid           = 1'b1;
            trailer_window_next = '0;
            trailer_count_next  = '0;
            if (window_shift == term_cmp) begin
              res.kind           = KIND_ACCEPT;
              phase_next         = PH_HEADER;
              header_count_next  = '0;
              check_residue_next = '0;
            end else begin
              res.kind   = KIND_MISMATCH;
              phase_next = PH_HUNT;
            end
          end
        end
        PH_HUNT: begin
          trailer_window_next = window_shift;
          trailer_count_next  = count_sat;
          if (count_sat == TB_CNT && window_shift == term_cmp) begin
            res_valid           = 1'b1;
            res.kind            = KIND_RESYNC;
            phase_next          = PH_HEADER;
            header_count_next   = '0;
            check_residue_next  = '0;
            trailer_window_next = '0;
            trailer_count_next  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      check_residue  <= '0;
      type_reg       <= '0;
      priority_reg   <= '0;
      length_reg     <= '0;
      payload_count  <= '0;
      trailer_window <= '0;
      trailer_count  <= '0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      check_residue  <= check_residue_next;
      type_reg       <= type_reg_next;
      priority_reg   <= priority_reg_next;
      length_reg     <= length_reg_next;
      payload_count  <= payload_count_next;
      trailer_window <= trailer_window_next;
      trailer_count  <= trailer_count_next;
    end
  end

  assign q_push = accept && res_valid;
  assign q_item = res;

endmodule

@@ rtl/core/mhfd_fifo.sv @@
// Short result queue between the front end and the output stage.
// Depends on mhfd_pkg for the item type and depth; uses the assertion macros.
`include "mod7_header_frame_deframer_assert.svh"
module mhfd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mhfd_pkg::res_item_t wr_data,
  input  logic                pop,
  output mhfd_pkg::res_item_t rd_data,
  output logic                full,
  output logic                empty
);
  import mhfd_pkg::*;

  res_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `MHFD_ASSERT(a_no_overflow, push |-> !full)
  `MHFD_ASSERT(a_no_underflow, pop |-> !empty)
  `MHFD_ASSERT(a_count_tracks, (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))

endmodule

@@ rtl/core/mhfd_back.sv @@
// Output stage: pops queued results, clears fields that do not apply to the
// result kind, and holds the item in an output register. Depends on mhfd_pkg.
`include "mod7_header_frame_deframer_assert.svh"
module mhfd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mhfd_pkg::res_item_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          result_kind,
  output logic [7:0]          data_byte,
  output logic [7:0]          frame_type,
  output logic [7:0]          frame_priority,
  output logic [15:0]         payload_length,
  output logic [15:0]         byte_index
);
  import mhfd_pkg::*;

  logic hdr_en;
  logic pay_en;

  assign q_pop  = !q_empty && (!out_valid || out_ready);
  assign hdr_en = (q_data.kind != KIND_RESYNC);
  assign pay_en = (q_data.kind == KIND_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_kind    <= q_data.kind;
      data_byte      <= pay_en ? q_data.data : 8'd0;
      byte_index     <= pay_en ? q_data.idx : 16'd0;
      frame_type     <= hdr_en ? q_data.ftype : 8'd0;
      frame_priority <= hdr_en ? q_data.fprio : 8'd0;
      payload_length <= hdr_en ? q_data.flen : 16'd0;
    end
  end

  `MHFD_ASSERT_ALWAYS(a_rst_clears_valid, rst |=> !out_valid)
  `MHFD_ASSERT(a_pop_loads, q_pop |=> out_valid)
  `MHFD_ASSERT(a_resync_no_header,
      (out_valid && result_kind == KIND_RESYNC) |-> (frame_type == 8'd0 && payload_length == 16'd0))
  `MHFD_ASSERT(a_nonpayload_clear,
      (out_valid && result_kind != KIND_PAYLOAD) |-> (data_byte == 8'd0 && byte_index == 16'd0))

endmodule

@@ rtl/core/mod7_header_frame_deframer.sv @@
// Top level of the mod-7 header frame deframer: register file, front end,
// result queue and output stage. Depends on mhfd_pkg and the mhfd_* modules.
//
//   Channel   Signals                                      Direction
//   input     in_valid, in_ready, rx_byte                  byte stream in
//   output    out_valid, out_ready, result_kind .. index   results out
//   config    psel, penable, pwrite, paddr, pwdata, prdata  APB register access
//
// One byte is accepted per cycle while the four-entry result queue has room.
// A result is queued, then loaded into the output register once it is free.
// A stalled output fills the queue; in_ready drops only when the queue is full.
// Reset is synchronous and returns the block to header phase with control and
// config registers at their reset values; no clearing pass is needed.
module mod7_header_frame_deframer #(
  parameter int TRAILER_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_priority,
  output logic [15:0] payload_length,
  output logic [15:0] byte_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mhfd_pkg::*;

  cfg_t      cfg;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  res_item_t q_wr;
  res_item_t q_rd;

  assign pready = 1'b1;

  mhfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_sel (paddr[3]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mhfd_front #(
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wr)
  );

  mhfd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  mhfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .data_byte      (data_byte),
    .frame_type     (frame_type),
    .frame_priority (frame_priority),
    .payload_length (payload_length),
    .byte_index     (byte_index)
  );

endmodule
